// File: rtl/core/mkped_pkg.sv
// shared types, event codes and reset values for the key event detector
`timescale 1ns / 1ps

package mkped_pkg;

    // fixed geometry
    localparam int unsigned NUM_FIELDS    = 5;
    localparam int unsigned KEY_COUNT_DEF = 5;
    localparam int unsigned CNT_W         = 16;
    localparam int unsigned EV_W          = 3;
    localparam int unsigned CFG_IDX_W     = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 2'd2;

    // register reset values
    localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CNT_W-1:0] LONG_RST     = 16'd100;
    localparam logic [CNT_W-1:0] REPEAT_RST   = 16'd20;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE      = 3'd0;
    localparam logic [EV_W-1:0] EV_PRESS     = 3'd1;
    localparam logic [EV_W-1:0] EV_SHORT_REL = 3'd2;
    localparam logic [EV_W-1:0] EV_LONG      = 3'd3;
    localparam logic [EV_W-1:0] EV_REPEAT    = 3'd4;
    localparam logic [EV_W-1:0] EV_LONG_REL  = 3'd5;

    // per-key phase, one-hot
    typedef enum logic [3:0] {
        PH_WAIT     = 4'b0001,
        PH_DEBOUNCE = 4'b0010,
        PH_LONG     = 4'b0100,
        PH_REPEAT   = 4'b1000
    } phase_t;

    // reload values shared by all lanes
    typedef struct packed {
        logic [CNT_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] long_press_ticks;
        logic [CNT_W-1:0] repeat_ticks;
    } cfg_t;

    // one event code per key
    typedef logic [NUM_FIELDS-1:0][EV_W-1:0] event_vec_t;

endpackage

// File: rtl/core/mkped_lane.sv
// one key lane: phase machine with debounce, long-press and repeat counters
`timescale 1ns / 1ps

module mkped_lane
    import mkped_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic            tick,
    input  logic            pressed,
    output logic [EV_W-1:0] ev
);

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] deb_reg, deb_next;
    logic [CNT_W-1:0] long_reg, long_next;
    logic [CNT_W-1:0] rep_reg, rep_next;

    // phase transitions and counter updates for one scan tick
    always_comb
    begin
        phase_next = phase_reg;
        deb_next   = deb_reg;
        long_next  = long_reg;
        rep_next   = rep_reg;
        ev         = EV_NONE;
        unique case (phase_reg)
            PH_WAIT:
            begin
                if (pressed)
                begin
                    phase_next = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE:
            begin
                if (pressed)
                begin
                    if (deb_reg == CNT_W'(1))
                    begin
                        deb_next   = cfg.debounce_ticks;
                        phase_next = PH_LONG;
                        ev         = EV_PRESS;
                    end
                    else
                    begin
                        deb_next = deb_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    deb_next   = cfg.debounce_ticks;
                    phase_next = PH_WAIT;
                end
            end
            PH_LONG:
            begin
                if (pressed)
                begin
                    if (long_reg == CNT_W'(1))
                    begin
                        long_next  = cfg.long_press_ticks;
                        phase_next = PH_REPEAT;
                        ev         = EV_LONG;
                    end
                    else
                    begin
                        long_next = long_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    long_next  = cfg.long_press_ticks;
                    phase_next = PH_WAIT;
                    ev         = EV_SHORT_REL;
                end
            end
            PH_REPEAT:
            begin
                if (pressed)
                begin
                    if (rep_reg == CNT_W'(1))
                    begin
                        rep_next = cfg.repeat_ticks;
                        ev       = EV_REPEAT;
                    end
                    else
                    begin
                        rep_next = rep_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    rep_next   = cfg.repeat_ticks;
                    phase_next = PH_WAIT;
                    ev         = EV_LONG_REL;
                end
            end
            default:
            begin
                phase_next = PH_WAIT;
            end
        endcase
    end

    // state advances only on an input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            deb_reg   <= DEBOUNCE_RST;
            long_reg  <= LONG_RST;
            rep_reg   <= REPEAT_RST;
        end
        else if (tick)
        begin
            phase_reg <= phase_next;
            deb_reg   <= deb_next;
            long_reg  <= long_next;
            rep_reg   <= rep_next;
        end
    end

    // a waiting key never reports
    a_wait_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WAIT) |-> (ev == EV_NONE))
        else $error("event reported from wait phase");

    // a confirmed press lands in long-press wait
    a_press_to_long: assert property (@(posedge clk) disable iff (!rst_n)
        (tick && ev == EV_PRESS) |=> (phase_reg == PH_LONG))
        else $error("press not followed by long-press wait");

    // any released tick returns the key to wait
    a_release_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (tick && !pressed) |=> (phase_reg == PH_WAIT))
        else $error("release did not return key to wait");

endmodule

// File: rtl/core/mkped_merge.sv
// merge stage: gathers lane events into an output register with a skid slot
`timescale 1ns / 1ps

module mkped_merge
    import mkped_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  event_vec_t lane_ev,
    output logic       out_valid,
    input  logic       out_stall,
    output event_vec_t out_ev
);

    logic       out_valid_reg, out_valid_next;
    logic       skid_valid_reg, skid_valid_next;
    event_vec_t out_reg, out_next;
    event_vec_t skid_reg, skid_next;
    logic       accept;
    logic       out_take;

    // stall only once the skid slot is holding a result
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    // output register refill and skid slot handling
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                if (accept)
                begin
                    out_next = lane_ev;
                end
            end
        end
        else if (accept)
        begin
            skid_next       = lane_ev;
            skid_valid_next = 1'b1;
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload flops
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_ev    = out_reg;

    // skid slot is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full while output register empty");

    // a transfer into an empty stage goes straight to the output register
    a_direct_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_valid_reg) |=> (out_valid_reg && !skid_valid_reg))
        else $error("transfer into empty stage not presented");

    // a parked result holds while the receiver stalls
    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_stall) |=> (skid_valid_reg && $stable(skid_reg)))
        else $error("skid slot lost its result under stall");

endmodule

// File: rtl/core/multi_key_press_event_detector_core.sv
// top level of the multi-key press event detector
//
// Usage: each input transfer on key_levels is one scan tick, bit k high while
// key k is held. Every tick yields exactly one output transfer carrying an
// event code per key on event_key0..event_key4: 0 none, 1 press confirmed,
// 2 short release, 3 long press, 4 auto-repeat, 5 release after long press.
// Keys at or above KEY_COUNT always report 0.
// One tick is taken every cycle while in_stall is low; each key has its own
// lane, so the rate is set only by the output register and skid slot, which
// stall the input after two results are parked behind a stalled receiver.
// Reload values are written through cfg_we/cfg_index/cfg_data (index 0
// debounce, 1 long press, 2 repeat); a write takes effect at the next reload
// of a counter. Unknown indexes are ignored.
// Reset (rst_n low, asynchronous) puts every key in the wait phase, loads
// the counters and registers with 20, 100 and 20 and empties the output.
// While out_stall is high the presented result holds and in_stall rises once
// the skid slot is in use.
`timescale 1ns / 1ps

module multi_key_press_event_detector_core
    import mkped_pkg::*;
#(
    parameter int unsigned KEY_COUNT = KEY_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [NUM_FIELDS-1:0] key_levels,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [EV_W-1:0]      event_key0,
    output logic [EV_W-1:0]      event_key1,
    output logic [EV_W-1:0]      event_key2,
    output logic [EV_W-1:0]      event_key3,
    output logic [EV_W-1:0]      event_key4
);

    cfg_t       cfg_reg;
    event_vec_t lane_ev;
    event_vec_t out_ev;
    logic       in_xfer;

    assign in_xfer = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= DEBOUNCE_RST;
            cfg_reg.long_press_ticks <= LONG_RST;
            cfg_reg.repeat_ticks     <= REPEAT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE: cfg_reg.debounce_ticks   <= cfg_data;
                CFG_LONG:     cfg_reg.long_press_ticks <= cfg_data;
                CFG_REPEAT:   cfg_reg.repeat_ticks     <= cfg_data;
                default:      ;
            endcase
        end
    end

    // one lane per key in use, idle codes for the rest
    for (genvar k = 0; k < NUM_FIELDS; k++)
    begin : g_lane
        if (k < KEY_COUNT)
        begin : g_used
            mkped_lane u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .cfg     (cfg_reg),
                .tick    (in_xfer),
                .pressed (key_levels[k]),
                .ev      (lane_ev[k])
            );
        end
        else
        begin : g_unused
            assign lane_ev[k] = EV_NONE;
        end
    end

    // merge lane events into the output stage
    mkped_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .lane_ev   (lane_ev),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_ev    (out_ev)
    );

    assign event_key0 = out_ev[0];
    assign event_key1 = out_ev[1];
    assign event_key2 = out_ev[2];
    assign event_key3 = out_ev[3];
    assign event_key4 = out_ev[4];

endmodule

// File: tb/key_event_checker.sv
// transfer monitor, event predictor and result comparator for the key event detector
`timescale 1ns / 1ps

module key_event_checker
    import mkped_pkg::*;
#(
    parameter int unsigned KEY_COUNT = KEY_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CNT_W-1:0]      cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [NUM_FIELDS-1:0] key_levels,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [EV_W-1:0]       event_key0,
    input  logic [EV_W-1:0]       event_key1,
    input  logic [EV_W-1:0]       event_key2,
    input  logic [EV_W-1:0]       event_key3,
    input  logic [EV_W-1:0]       event_key4,
    output int                    errors,
    output int                    pending,
    output int                    checked
);

    // predicted per-key state and reload values
    cfg_t             reload;
    phase_t           phase_r  [NUM_FIELDS];
    logic [CNT_W-1:0] deb_left [NUM_FIELDS];
    logic [CNT_W-1:0] lng_left [NUM_FIELDS];
    logic [CNT_W-1:0] rep_left [NUM_FIELDS];

    // event vectors still owed by the block, oldest first
    event_vec_t events_due [$];
    int         err_n;
    int         chk_n;

    // advance every key lane by one scan tick and return the events it raises
    function automatic event_vec_t next_key_events(input logic [NUM_FIELDS-1:0] lv);
        event_vec_t ev;
        ev = '0;
        for (int k = 0; k < NUM_FIELDS; k++)
        begin
            if (k < KEY_COUNT)
            begin
                case (phase_r[k])
                    PH_WAIT:
                    begin
                        if (lv[k])
                            phase_r[k] = PH_DEBOUNCE;
                    end
                    PH_DEBOUNCE:
                    begin
                        if (lv[k])
                        begin
                            // a counter at zero wraps and stays silent
                            deb_left[k] = deb_left[k] - 1'b1;
                            if (deb_left[k] == '0)
                            begin
                                deb_left[k] = reload.debounce_ticks;
                                phase_r[k]  = PH_LONG;
                                ev[k]       = EV_PRESS;
                            end
                        end
                        else
                        begin
                            deb_left[k] = reload.debounce_ticks;
                            phase_r[k]  = PH_WAIT;
                        end
                    end
                    PH_LONG:
                    begin
                        if (lv[k])
                        begin
                            lng_left[k] = lng_left[k] - 1'b1;
                            if (lng_left[k] == '0)
                            begin
                                lng_left[k] = reload.long_press_ticks;
                                phase_r[k]  = PH_REPEAT;
                                ev[k]       = EV_LONG;
                            end
                        end
                        else
                        begin
                            lng_left[k] = reload.long_press_ticks;
                            phase_r[k]  = PH_WAIT;
                            ev[k]       = EV_SHORT_REL;
                        end
                    end
                    default:
                    begin
                        if (lv[k])
                        begin
                            rep_left[k] = rep_left[k] - 1'b1;
                            if (rep_left[k] == '0)
                            begin
                                rep_left[k] = reload.repeat_ticks;
                                ev[k]       = EV_REPEAT;
                            end
                        end
                        else
                        begin
                            rep_left[k] = reload.repeat_ticks;
                            phase_r[k]  = PH_WAIT;
                            ev[k]       = EV_LONG_REL;
                        end
                    end
                endcase
            end
        end
        return ev;
    endfunction

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        event_vec_t got;
        event_vec_t want;
        if (!rst_n)
        begin
            reload.debounce_ticks   = DEBOUNCE_RST;
            reload.long_press_ticks = LONG_RST;
            reload.repeat_ticks     = REPEAT_RST;
            for (int k = 0; k < NUM_FIELDS; k++)
            begin
                phase_r[k]  = PH_WAIT;
                deb_left[k] = DEBOUNCE_RST;
                lng_left[k] = LONG_RST;
                rep_left[k] = REPEAT_RST;
            end
            events_due.delete();
            err_n = 0;
            chk_n = 0;
            errors  <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            // result transfer against the oldest prediction
            if (out_valid && !out_stall)
            begin
                got[0] = event_key0;
                got[1] = event_key1;
                got[2] = event_key2;
                got[3] = event_key3;
                got[4] = event_key4;
                if (events_due.size() == 0)
                begin
                    err_n++;
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                end
                else
                begin
                    want = events_due.pop_front();
                    chk_n++;
                    for (int k = 0; k < NUM_FIELDS; k++)
                    begin
                        if (got[k] !== want[k])
                        begin
                            err_n++;
                            $display("%0t: event_key%0d expected %0d, got %0d",
                                     $time, k, want[k], got[k]);
                        end
                    end
                end
            end

            // scan tick transfer
            if (in_valid && !in_stall)
                events_due.push_back(next_key_events(key_levels));

            // reload values take effect at the next reload only
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE: reload.debounce_ticks   = cfg_data;
                    CFG_LONG:     reload.long_press_ticks = cfg_data;
                    CFG_REPEAT:   reload.repeat_ticks     = cfg_data;
                    default:      ;
                endcase
            end

            errors  <= err_n;
            pending <= events_due.size();
            checked <= chk_n;
        end
    end

endmodule

// File: tb/testbench.sv
// top of the key event detector testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
    import mkped_pkg::*;

    // index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 80;
    localparam int WRAP_HOLD   = 20;
    localparam int RUN_CAP     = 60;
    localparam int NUM_PHASES  = 6;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CNT_W-1:0]      cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [NUM_FIELDS-1:0] key_levels = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [EV_W-1:0]       event_key0;
    logic [EV_W-1:0]       event_key1;
    logic [EV_W-1:0]       event_key2;
    logic [EV_W-1:0]       event_key3;
    logic [EV_W-1:0]       event_key4;

    int errors;
    int pending;
    int checked;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_reqs  = 0;
    int hold_taken = 0;
    int hold_left  = 0;
    int ticks_sent = 0;
    int settings   = 0;
    int cur_deb;
    int cur_long;
    int cur_rep;
    int   run_left [NUM_FIELDS];
    logic held     [NUM_FIELDS];

    // register settings of the random phases
    int ph_deb   [NUM_PHASES] = '{1, 3, 2, 4, 1, 65535};
    int ph_long  [NUM_PHASES] = '{2, 5, 4, 6, 1, 65535};
    int ph_rep   [NUM_PHASES] = '{1, 2, 3, 1, 1, 65535};
    int ph_ticks [NUM_PHASES] = '{130, 130, 130, 130, 90, 40};

    // opening sequence, all keys together then key subsets
    logic [NUM_FIELDS-1:0] opening [24] = '{
        5'h1F, 5'h00,
        5'h1F, 5'h1F, 5'h00,
        5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h00,
        5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h00,
        5'h15, 5'h15, 5'h00,
        5'h0A, 5'h0A, 5'h00
    };

    multi_key_press_event_detector_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_levels (key_levels),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_key0 (event_key0),
        .event_key1 (event_key1),
        .event_key2 (event_key2),
        .event_key3 (event_key3),
        .event_key4 (event_key4)
    );

    key_event_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_levels (key_levels),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_key0 (event_key0),
        .event_key1 (event_key1),
        .event_key2 (event_key2),
        .event_key3 (event_key3),
        .event_key4 (event_key4),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked)
    );

    always #10 clk = ~clk;

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_reqs != hold_taken)
        begin
            hold_taken <= hold_reqs;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    // run ends here if the block stops moving
    initial
    begin
        #10_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // idle mix: none, sender gaps, receiver stalls, both
    task set_mix(input int m);
        case (m)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 52; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 37; stall_pct = 37; end
        endcase
    endtask

    // one scan tick transfer, with an optional gap in front
    task send_tick(input logic [NUM_FIELDS-1:0] lv);
        if ($urandom_range(99, 0) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99, 0) < idle_pct)
                @(posedge clk);
        end
        in_valid   <= 1'b1;
        key_levels <= lv;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        ticks_sent++;
    endtask

    task hold_keys(input logic [NUM_FIELDS-1:0] lv, input int count);
        repeat (count)
            send_tick(lv);
    endtask

    // stop offering and let every owed result come out
    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // stray write to the unused index, then all three reload values
    task write_regs(input int d, input int l, input int r);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_UNUSED;
        cfg_data  <= CNT_W'($urandom_range(65535, 0));
        @(posedge clk);
        cfg_index <= CFG_DEBOUNCE;
        cfg_data  <= d[CNT_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_LONG;
        cfg_data  <= l[CNT_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_REPEAT;
        cfg_data  <= r[CNT_W-1:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_deb  = d;
        cur_long = l;
        cur_rep  = r;
        settings++;
    endtask

    // per-key press and release runs sized around the current reload values
    task random_ticks(input int count);
        int                    len;
        int                    c;
        int                    base;
        logic [NUM_FIELDS-1:0] lv;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                set_mix((n / 40) % 4);
            for (int k = 0; k < NUM_FIELDS; k++)
            begin
                if (run_left[k] == 0)
                begin
                    held[k] = ~held[k];
                    if (held[k])
                    begin
                        c    = $urandom_range(99, 0);
                        base = cur_deb + cur_long + 1;
                        if (c < 25)
                            len = $urandom_range(cur_deb + 1, 1);
                        else if (c < 55)
                            len = $urandom_range(base, cur_deb + 1);
                        else
                            len = $urandom_range(base + 3 * cur_rep, base);
                        if (len > RUN_CAP)
                            len = RUN_CAP;
                    end
                    else
                        len = $urandom_range(4, 1);
                    run_left[k] = len;
                end
                lv[k] = held[k];
                run_left[k]--;
            end
            // occasional noise tick that breaks the runs
            if ($urandom_range(99, 0) < 10)
                lv = NUM_FIELDS'($urandom_range(31, 0));
            send_tick(lv);
        end
    endtask

    initial
    begin
        for (int k = 0; k < NUM_FIELDS; k++)
        begin
            run_left[k] = 0;
            held[k]     = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: cancelled debounce, short and long presses, repeats
        set_mix(0);
        write_regs(1, 2, 1);
        foreach (opening[i])
            send_tick(opening[i]);
        drain();

        // random phases over several reload settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_regs(ph_deb[p], ph_long[p], ph_rep[p]);
            if (p == 0 || p == 3)
                hold_reqs++;
            random_ticks(ph_ticks[p]);
            drain();
        end

        // zero reload values: counters wrap past zero without firing
        set_mix(0);
        write_regs(0, 0, 0);
        hold_keys(5'h1F, 12);
        send_tick(5'h00);
        hold_keys(5'h1F, WRAP_HOLD);
        send_tick(5'h00);
        drain();

        // back to the reset values
        write_regs(int'(DEBOUNCE_RST), int'(LONG_RST), int'(REPEAT_RST));
        random_ticks(30);
        drain();

        $display("covered %0d scan ticks under %0d reload settings, four idle mixes",
                 ticks_sent, settings);
        $display("and long receiver hold-offs; %0d results compared, %0d mismatches",
                 checked, errors);
        if (errors == 0 && pending == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: multi_key_press_event_detector_core.f
rtl/core/mkped_pkg.sv
rtl/core/mkped_lane.sv
rtl/core/mkped_merge.sv
rtl/core/multi_key_press_event_detector_core.sv
tb/key_event_checker.sv
tb/testbench.sv
